[sv/srfp_pkg.sv]
// Shared types and constants for the servo reply frame parser.
`timescale 1ns / 1ps

package srfp_pkg;

  // Frame layout
  localparam int unsigned FRAME_LEN = 8;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned SLOT_W    = $clog2(FRAME_LEN);

  localparam logic [7:0] HDR_FIRST  = 8'hFF;
  localparam logic [7:0] HDR_SECOND = 8'hF5;

  // Slot positions within the frame
  localparam logic [SLOT_W-1:0] SLOT_ID    = SLOT_W'(2);
  localparam logic [SLOT_W-1:0] SLOT_POS_H = SLOT_W'(5);
  localparam logic [SLOT_W-1:0] SLOT_POS_L = SLOT_W'(6);
  localparam logic [IDX_W-1:0]  IDX_BODY   = IDX_W'(2);
  localparam logic [IDX_W-1:0]  IDX_LAST   = IDX_W'(FRAME_LEN - 1);

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_SAW_FIRST = 2'd1,
    PH_BODY      = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0]  servo_id;
    logic        checksum_ok;
    logic [15:0] position_value;
  } result_t;

endpackage

[sv/srfp_in_stage.sv]
// Input register stage: holds one received word until the parser takes it.
`timescale 1ns / 1ps

module srfp_in_stage
  import srfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       advance,
  output logic       s1_valid,
  output logic [7:0] s1_byte
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r,  s1_byte_nxt;

  // Stall only while a held word cannot move on
  assign in_stall = s1_valid_r && !advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_byte_nxt  = s1_byte_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
      if (in_valid) begin
        s1_byte_nxt = in_rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_byte_r <= s1_byte_nxt;
  end

  assign s1_valid = s1_valid_r;
  assign s1_byte  = s1_byte_r;

endmodule

[sv/srfp_frame_fsm.sv]
// Header hunt, body capture and checksum of one reply frame.
`timescale 1ns / 1ps

module srfp_frame_fsm
  import srfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output result_t    res
);

  phase_t           phase_r, phase_nxt;
  logic [IDX_W-1:0] idx_r,   idx_nxt;
  // Body bytes; the header slots stay unused, the checksum word is used as it arrives
  logic [7:0]       body_r [FRAME_LEN];
  logic             wr_en;
  logic [9:0]       sum;
  logic [7:0]       chk;
  logic             ok;

  // Next phase, store write and completion
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    wr_en     = 1'b0;
    res_valid = 1'b0;
    if (fire) begin
      unique case (phase_r)
        PH_SAW_FIRST: begin
          if (rx_byte == HDR_SECOND) begin
            phase_nxt = PH_BODY;
            idx_nxt   = IDX_BODY;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_BODY: begin
          wr_en   = 1'b1;
          idx_nxt = idx_r + IDX_W'(1);
          if (idx_r >= IDX_LAST) begin
            phase_nxt = PH_IDLE;
            res_valid = 1'b1;
          end
        end
        default: begin
          if (rx_byte == HDR_FIRST) begin
            phase_nxt = PH_SAW_FIRST;
          end else if (rx_byte == HDR_SECOND) begin
            phase_nxt = PH_BODY;
            idx_nxt   = IDX_BODY;
          end
        end
      endcase
    end
  end

  // Checksum over bytes 2..6 against the arriving byte 7
  always_comb begin
    sum = 10'(body_r[2]) + 10'(body_r[3]) + 10'(body_r[4])
        + 10'(body_r[5]) + 10'(body_r[6]);
    chk = ~sum[7:0];
    ok  = (chk == rx_byte);
    res.servo_id       = body_r[SLOT_ID];
    res.checksum_ok    = ok;
    res.position_value = ok ? {body_r[SLOT_POS_H], body_r[SLOT_POS_L]} : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      idx_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Write the body slot
  always_ff @(posedge clk) begin
    if (wr_en) begin
      body_r[idx_r[SLOT_W-1:0]] <= rx_byte;
    end
  end

endmodule

[sv/srfp_out_reg.sv]
// Result register: holds a finished result until the receiver takes it.
`timescale 1ns / 1ps

module srfp_out_reg
  import srfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic        res_valid,
  input  result_t     res,
  output logic        advance,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_servo_id,
  output logic        out_checksum_ok,
  output logic [15:0] out_position_value
);

  logic    out_valid_r, out_valid_nxt;
  result_t res_r,       res_nxt;

  // Free when empty or when the held word leaves this cycle
  assign advance = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    if (advance) begin
      out_valid_nxt = fire && res_valid;
      if (fire && res_valid) begin
        res_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_servo_id       = res_r.servo_id;
  assign out_checksum_ok    = res_r.checksum_ok;
  assign out_position_value = res_r.position_value;

endmodule

[sv/servo_reply_frame_parser_unit.sv]
// Servo reply frame parser: accepts received bytes, finds reply frames and
// reports id, checksum status and the 16-bit value of each complete frame.
//
// Input channel: in_valid / in_stall carry one received byte (in_rx_byte)
// per word. Output channel: out_valid / out_stall carry one result word per
// complete frame: 8 bytes from header 0xFF 0xF5, or 7 from a lone 0xF5
// while idle. The word carrying the frame's last byte passes the input
// register and then the parse, and its result is taken into the result
// register. Throughput: one byte per cycle while the result register is
// free (empty, or its held word leaving); the parse step sits between the
// input register and the result register.
// Reset (rst_n low, synchronous) empties both registers and returns the
// hunt to idle. When the receiver stalls, the held result stays put; one
// further byte may be accepted into the input register, and in_stall rises
// only once that byte cannot move on.
`timescale 1ns / 1ps

module servo_reply_frame_parser_unit
  import srfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_servo_id,
  output logic        out_checksum_ok,
  output logic [15:0] out_position_value
);

  logic       advance;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       fire;
  logic       res_valid;
  result_t    res;

  assign fire = s1_valid && advance;

  srfp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .advance    (advance),
    .s1_valid   (s1_valid),
    .s1_byte    (s1_byte)
  );

  srfp_frame_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .rx_byte   (s1_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  srfp_out_reg u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .fire               (fire),
    .res_valid          (res_valid),
    .res                (res),
    .advance            (advance),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_servo_id       (out_servo_id),
    .out_checksum_ok    (out_checksum_ok),
    .out_position_value (out_position_value)
  );

endmodule

[sv/srfp_checker.sv]
// Port-level checks for the servo reply frame parser, bound to the top level.
`timescale 1ns / 1ps

module srfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_rx_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_servo_id,
  input logic        out_checksum_ok,
  input logic [15:0] out_position_value
);

  // A stalled input word holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_rx_byte))
    else $error("stalled input word changed");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_servo_id)
      && $stable(out_checksum_ok) && $stable(out_position_value))
    else $error("stalled result word changed");

  // Failed checksum forces the value to zero
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_checksum_ok |-> out_position_value == 16'd0)
    else $error("value not zero on checksum failure");

  // Input back-pressure only comes from a stalled full output
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // A new result follows an accepted byte
  a_res_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a preceding accepted byte");

endmodule

bind servo_reply_frame_parser_unit srfp_checker u_srfp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_rx_byte         (in_rx_byte),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_servo_id       (out_servo_id),
  .out_checksum_ok    (out_checksum_ok),
  .out_position_value (out_position_value)
);
